// ===== hw/rtl/paired_read_overlap_merge_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the paired read overlap merge block
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAIRED_READ_OVERLAP_MERGE_DEFINES_SVH
`define PAIRED_READ_OVERLAP_MERGE_DEFINES_SVH

// condition holds at every edge
`define PROM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PROM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define PROM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/prom_pkg.sv =====
// ----------------------------------------------------------------------------
// prom_pkg
// Types, codes and helper functions for the paired read overlap merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prom_pkg;

	localparam int S_TDATA_W  = 32;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 56;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [8:0] QUAL_BASE = 9'd33;
	localparam logic [8:0] QUAL_TOP  = 9'd126;

	localparam logic [8:0] RST_MIN_OVERLAP = 9'd30;
	localparam logic [6:0] RST_HIGH_QUAL   = 7'd63;
	localparam logic [6:0] RST_LOW_QUAL    = 7'd48;
	localparam logic [3:0] RST_MAX_LOW     = 4'd3;

	typedef enum logic [1:0] {
		KIND_LOAD_LEFT  = 2'd0,
		KIND_LOAD_RIGHT = 2'd1,
		KIND_MERGE      = 2'd2,
		KIND_FETCH      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_MIN_OVERLAP = 2'd0,
		CFG_HIGH_QUAL   = 2'd1,
		CFG_LOW_QUAL    = 2'd2,
		CFG_MAX_LOW     = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MRD,
		S_MCMP,
		S_MDONE,
		S_FRD,
		S_FOUT
	} state_t;

	function automatic logic [7:0] complement(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h41:   r = 8'h54;
			8'h54:   r = 8'h41;
			8'h43:   r = 8'h47;
			8'h47:   r = 8'h43;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic left_wins(input logic [7:0] ql, input logic [7:0] qr,
		input logic [6:0] hi, input logic [6:0] lo);
		return (ql >= {1'b0, hi}) && (qr <= {1'b0, lo});
	endfunction

	function automatic logic is_low_diff(input logic [7:0] ql, input logic [7:0] qr,
		input logic [6:0] hi, input logic [6:0] lo);
		return left_wins(ql, qr, hi, lo) || ((ql <= {1'b0, lo}) && (qr >= {1'b0, hi}));
	endfunction

	// agreeing bases: summed quality, clamped into the printable range
	function automatic logic [7:0] qual_sum(input logic [7:0] ql, input logic [7:0] qr);
		logic [8:0] sum;
		logic [8:0] adj;
		logic [7:0] r;
		sum = {1'b0, ql} + {1'b0, qr};
		adj = sum - QUAL_BASE;
		if (sum < (QUAL_BASE + QUAL_BASE)) begin
			r = QUAL_BASE[7:0];
		end else if (adj > QUAL_TOP) begin
			r = QUAL_TOP[7:0];
		end else begin
			r = adj[7:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prom_ram.sv =====
// ----------------------------------------------------------------------------
// prom_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prom_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wr_data;
		end
		rd_data <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/paired_read_overlap_merge.sv =====
// ----------------------------------------------------------------------------
// paired_read_overlap_merge
// Loads a left and a right read, searches the shortest acceptable overlap
// with one shared compare unit, and reads out the merged read.
//
//   channel   dir  fields
//   s_axis    in   tdata: base, qual, position   tuser: kind, first
//   m_axis    out  tdata: overlapped, offset, overlap_len, diff_count,
//                         merged_len, out_base, out_qual
//   cfg       in   cfg_index, cfg_data (always ready)
//
// Load transaction: no result.
// Fetch transaction: the position is registered, then both RAMs are read, then
// the merge logic result is registered into the output register.
// Merge transaction: a RAM read state and a compare state per base pair,
// over every overlap length tried, then a done state; the single RAM port
// of each read sets the pace. s_axis is not ready until the result is taken
// into the output register, which stalls only while m_axis holds a result.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "paired_read_overlap_merge_defines.svh"

module paired_read_overlap_merge #(
	parameter int MAX_READ_LEN = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] base, [15:8] qual, [24:16] position, [31:25] zero
	input  logic [prom_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] kind, [2] first
	input  logic [prom_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] overlapped, [9:1] offset, [18:10] overlap_len, [22:19] diff_count,
	// [32:23] merged_len, [40:33] out_base, [48:41] out_qual, [55:49] zero
	output logic [prom_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [prom_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prom_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import prom_pkg::*;

	localparam int AW = $clog2(MAX_READ_LEN);
	localparam int CW = $clog2(MAX_READ_LEN + 1);
	localparam int XW = (CW > 9) ? CW : 9;
	localparam int EW = XW + 1;

	state_t state_q, state_d;

	logic [8:0] min_ovl_q;
	logic [6:0] hi_q;
	logic [6:0] lo_q;
	logic [3:0] maxlow_q;

	logic [CW-1:0] lcnt_q, rcnt_q;
	logic          found_q;
	logic [CW-1:0] fovl_q;
	logic [3:0]    fdiff_q;
	logic [CW-1:0] olen_q, idx_q;
	logic [3:0]    dcnt_q;
	logic [8:0]    pos_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	kind_t      in_kind;
	logic       in_first;
	logic [7:0] in_base, in_qual;
	logic [8:0] in_pos;
	logic       accept, out_free, emit;

	logic [CW-1:0] shorter;
	logic [XW-1:0] min_eff;
	logic          start_ok;

	logic          l_we, r_we;
	logic [AW-1:0] l_addr, r_addr;
	logic [15:0]   l_rdata, r_rdata;
	logic [CW-1:0] l_wcnt, r_wcnt;
	logic          l_room, r_room;

	logic [7:0] lb, lq, rb, rq;
	logic       mism, lowd, fail, last;
	logic [3:0] dcnt_inc;

	logic [EW-1:0] off_e, ovl_e, mlen_e, pos_e, idx_e;
	logic [7:0]    res_base, res_qual;
	logic [M_TDATA_W-1:0] res_data;

	assign in_kind  = kind_t'(s_axis_tuser[1:0]);
	assign in_first = s_axis_tuser[2];
	assign in_base  = s_axis_tdata[7:0];
	assign in_qual  = s_axis_tdata[15:8];
	assign in_pos   = s_axis_tdata[24:16];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	assign shorter  = (lcnt_q < rcnt_q) ? lcnt_q : rcnt_q;
	assign min_eff  = (min_ovl_q == 9'd0) ? XW'(1) : XW'(min_ovl_q);
	assign start_ok = min_eff <= XW'(shorter);

	assign l_wcnt = in_first ? '0 : lcnt_q;
	assign r_wcnt = in_first ? '0 : rcnt_q;
	assign l_room = l_wcnt < CW'(MAX_READ_LEN);
	assign r_room = r_wcnt < CW'(MAX_READ_LEN);

	// held merge state, widened so narrow builds still fill the result fields
	assign ovl_e  = EW'(fovl_q);
	assign off_e  = EW'(lcnt_q) - ovl_e;
	assign mlen_e = off_e + EW'(rcnt_q);
	assign pos_e  = EW'(pos_q);
	assign idx_e  = pos_e - off_e;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_MERGE: state_d = start_ok ? S_MRD : S_MDONE;
						KIND_FETCH: state_d = S_FRD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_MRD:  state_d = S_MCMP;
			S_MCMP: begin
				if (fail) begin
					state_d = (olen_q >= shorter) ? S_MDONE : S_MRD;
				end else if (last) begin
					state_d = S_MDONE;
				end else begin
					state_d = S_MRD;
				end
			end
			S_MDONE: state_d = out_free ? S_IDLE : S_MDONE;
			S_FRD:   state_d = S_FOUT;
			S_FOUT:  state_d = out_free ? S_IDLE : S_FOUT;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		s_axis_tready = 1'b0;
		emit          = 1'b0;
		l_we          = 1'b0;
		r_we          = 1'b0;
		l_addr        = l_wcnt[AW-1:0];
		r_addr        = r_wcnt[AW-1:0];
		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				l_we = s_axis_tvalid && (in_kind == KIND_LOAD_LEFT) && l_room;
				r_we = s_axis_tvalid && (in_kind == KIND_LOAD_RIGHT) && r_room;
			end
			S_MRD, S_MCMP: begin
				l_addr = AW'(lcnt_q - olen_q + idx_q);
				r_addr = AW'(rcnt_q - CW'(1) - idx_q);
			end
			S_FRD, S_FOUT: begin
				l_addr = pos_e[AW-1:0];
				r_addr = AW'(EW'(rcnt_q) - EW'(1) - idx_e);
				emit   = (state_q == S_FOUT) && out_free;
			end
			S_MDONE: emit = out_free;
			default: ;
		endcase
	end

	prom_ram #(.WIDTH(16), .DEPTH(MAX_READ_LEN)) u_left_ram (
		.clk     (clk),
		.we      (l_we),
		.addr    (l_addr),
		.wr_data ({in_base, in_qual}),
		.rd_data (l_rdata)
	);

	prom_ram #(.WIDTH(16), .DEPTH(MAX_READ_LEN)) u_right_ram (
		.clk     (clk),
		.we      (r_we),
		.addr    (r_addr),
		.wr_data ({complement(in_base), in_qual}),
		.rd_data (r_rdata)
	);

	assign lb = l_rdata[15:8];
	assign lq = l_rdata[7:0];
	assign rb = r_rdata[15:8];
	assign rq = r_rdata[7:0];

	// shared compare unit: one base pair per pass
	assign mism     = lb != rb;
	assign lowd     = is_low_diff(lq, rq, hi_q, lo_q);
	assign dcnt_inc = dcnt_q + 4'd1;
	assign fail     = mism && (!lowd || (dcnt_inc >= maxlow_q));
	assign last     = (idx_q + CW'(1)) == olen_q;

	// ---------------- merged base and quality ----------------
	always_comb begin
		res_base = '0;
		res_qual = '0;
		if ((state_q == S_FOUT) && found_q && (pos_e < mlen_e)) begin
			if (pos_e < off_e) begin
				res_base = lb;
				res_qual = lq;
			end else if (idx_e < ovl_e) begin
				if (mism) begin
					if (left_wins(lq, rq, hi_q, lo_q)) begin
						res_base = lb;
						res_qual = lq;
					end else begin
						res_base = rb;
						res_qual = rq;
					end
				end else begin
					res_base = lb;
					res_qual = qual_sum(lq, rq);
				end
			end else begin
				res_base = rb;
				res_qual = rq;
			end
		end
	end

	always_comb begin
		res_data = '0;
		if (found_q) begin
			res_data[0]     = 1'b1;
			res_data[9:1]   = off_e[8:0];
			res_data[18:10] = ovl_e[8:0];
			res_data[22:19] = fdiff_q;
			res_data[32:23] = mlen_e[9:0];
		end
		res_data[40:33] = res_base;
		res_data[48:41] = res_qual;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			min_ovl_q <= RST_MIN_OVERLAP;
			hi_q      <= RST_HIGH_QUAL;
			lo_q      <= RST_LOW_QUAL;
			maxlow_q  <= RST_MAX_LOW;
			lcnt_q    <= '0;
			rcnt_q    <= '0;
			found_q   <= 1'b0;
			fovl_q    <= '0;
			fdiff_q   <= '0;
			olen_q    <= '0;
			idx_q     <= '0;
			dcnt_q    <= '0;
			pos_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MIN_OVERLAP: min_ovl_q <= cfg_data;
					CFG_HIGH_QUAL:   hi_q      <= cfg_data[6:0];
					CFG_LOW_QUAL:    lo_q      <= cfg_data[6:0];
					CFG_MAX_LOW:     maxlow_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_kind)
							KIND_LOAD_LEFT: begin
								lcnt_q  <= l_room ? l_wcnt + CW'(1) : l_wcnt;
								found_q <= 1'b0;
							end
							KIND_LOAD_RIGHT: begin
								rcnt_q  <= r_room ? r_wcnt + CW'(1) : r_wcnt;
								found_q <= 1'b0;
							end
							KIND_MERGE: begin
								found_q <= 1'b0;
								fovl_q  <= '0;
								fdiff_q <= '0;
								olen_q  <= min_eff[CW-1:0];
								idx_q   <= '0;
								dcnt_q  <= '0;
							end
							KIND_FETCH: pos_q <= in_pos;
							default: ;
						endcase
					end
				end
				S_MCMP: begin
					if (fail) begin
						olen_q <= olen_q + CW'(1);
						idx_q  <= '0;
						dcnt_q <= '0;
					end else if (last) begin
						found_q <= 1'b1;
						fovl_q  <= olen_q;
						fdiff_q <= mism ? dcnt_inc : dcnt_q;
					end else begin
						idx_q <= idx_q + CW'(1);
						if (mism) begin
							dcnt_q <= dcnt_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= res_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- assertions ----------------
	`PROM_ASSERT_ALWAYS(a_cnt_range, (lcnt_q <= CW'(MAX_READ_LEN)) && (rcnt_q <= CW'(MAX_READ_LEN)), "read length beyond capacity")
	`PROM_ASSERT_SAME(a_found_fits, found_q, (fovl_q != '0) && (fovl_q <= lcnt_q) && (fovl_q <= rcnt_q), "held overlap does not fit the reads")
	`PROM_ASSERT_SAME(a_scan_bounds, state_q == S_MRD, (idx_q < olen_q) && (olen_q <= shorter), "compare index outside overlap")
	`PROM_ASSERT_NEXT(a_load_clears, accept && ((in_kind == KIND_LOAD_LEFT) || (in_kind == KIND_LOAD_RIGHT)), !found_q, "load left merge result valid")

endmodule

`default_nettype wire

// ===== bench/paired_read_overlap_merge_tb.sv =====
// ----------------------------------------------------------------------------
// paired_read_overlap_merge_tb
// Drives left/right read loads, merge commands and merged-read fetches into
// the overlap merge block, models the overlap search and merged read in the
// bench, and checks every m_axis transaction in order against the model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module paired_read_overlap_merge_tb;

	import prom_pkg::*;

	localparam int READ_CAP = 256;
	localparam int QUIET    = 8;

	typedef struct packed {
		logic       overlapped;
		logic [8:0] offset;
		logic [8:0] ovl_len;
		logic [3:0] diffs;
		logic [9:0] merged_len;
		logic [7:0] base;
		logic [7:0] qual;
	} merge_report_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	logic [S_TUSER_W-1:0]   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// bench copy of the block state
	logic [7:0] lt_base [READ_CAP];
	logic [7:0] lt_qual [READ_CAP];
	logic [7:0] rt_base [READ_CAP];
	logic [7:0] rt_qual [READ_CAP];
	logic [8:0] lt_len    = '0;
	logic [8:0] rt_len    = '0;
	logic       hit       = 1'b0;
	logic [8:0] hit_len   = '0;
	logic [3:0] hit_diffs = '0;

	logic [8:0] min_ovl   = RST_MIN_OVERLAP;
	logic [6:0] hi_q      = RST_HIGH_QUAL;
	logic [6:0] lo_q      = RST_LOW_QUAL;
	logic [3:0] low_cap   = RST_MAX_LOW;

	merge_report_t pending_reports [$];
	int mismatches = 0;
	int items_sent = 0;
	int gap_pct    = 15;
	bit calm       = 1'b0;

	paired_read_overlap_merge dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// model
	// ------------------------------------------------------------------------
	function automatic logic [7:0] strand_swap(input logic [7:0] b);
		case (b)
			"A": return "T";
			"T": return "A";
			"C": return "G";
			"G": return "C";
			default: return b;
		endcase
	endfunction

	function automatic bit left_kept(input logic [7:0] ql, input logic [7:0] qr);
		return ql >= hi_q && qr <= lo_q;
	endfunction

	function automatic bit lopsided(input logic [7:0] ql, input logic [7:0] qr);
		return left_kept(ql, qr) || (ql <= lo_q && qr >= hi_q);
	endfunction

	// shortest acceptable overlap, left tail against reverse-complemented right head
	function automatic void search_overlap();
		int shorter, olen, off, diff, low, i;
		bit ok;
		shorter = (lt_len < rt_len) ? int'(lt_len) : int'(rt_len);
		hit = 1'b0;
		hit_len = '0;
		hit_diffs = '0;
		for (olen = (min_ovl == 0) ? 1 : int'(min_ovl); olen <= shorter && !hit; olen++) begin
			off = int'(lt_len) - olen;
			diff = 0;
			low = 0;
			ok = 1'b1;
			for (i = 0; i < olen && ok; i++) begin
				if (lt_base[off + i] != rt_base[int'(rt_len) - 1 - i]) begin
					diff++;
					if (lopsided(lt_qual[off + i], rt_qual[int'(rt_len) - 1 - i]))
						low++;
					if (diff > low || low >= low_cap)
						ok = 1'b0;
				end
			end
			if (ok) begin
				hit = 1'b1;
				hit_len = 9'(olen);
				hit_diffs = 4'(diff);
			end
		end
	endfunction

	function automatic void predict_item(input kind_t k, input bit first, input logic [7:0] b,
			input logic [7:0] q, input logic [8:0] pos);
		merge_report_t r;
		int off, mlen, i, sum;
		logic [7:0] lb, lq, rb, rq;
		r = '0;
		case (k)
			KIND_LOAD_LEFT: begin
				if (first)
					lt_len = '0;
				if (lt_len < READ_CAP) begin
					lt_base[lt_len] = b;
					lt_qual[lt_len] = q;
					lt_len++;
				end
				hit = 1'b0;
			end
			KIND_LOAD_RIGHT: begin
				if (first)
					rt_len = '0;
				if (rt_len < READ_CAP) begin
					rt_base[rt_len] = strand_swap(b);
					rt_qual[rt_len] = q;
					rt_len++;
				end
				hit = 1'b0;
			end
			default: begin
				if (k == KIND_MERGE)
					search_overlap();
				if (hit) begin
					off = int'(lt_len) - int'(hit_len);
					mlen = off + int'(rt_len);
					r.overlapped = 1'b1;
					r.offset = 9'(off);
					r.ovl_len = hit_len;
					r.diffs = hit_diffs;
					r.merged_len = 10'(mlen);
					if (k == KIND_FETCH && pos < mlen) begin
						if (pos < off) begin
							r.base = lt_base[pos];
							r.qual = lt_qual[pos];
						end else begin
							i = int'(pos) - off;
							rb = rt_base[int'(rt_len) - 1 - i];
							rq = rt_qual[int'(rt_len) - 1 - i];
							r.base = rb;
							r.qual = rq;
							if (i < hit_len) begin
								lb = lt_base[off + i];
								lq = lt_qual[off + i];
								if (lb != rb) begin
									if (left_kept(lq, rq)) begin
										r.base = lb;
										r.qual = lq;
									end
								end else begin
									sum = int'(lq) + int'(rq);
									r.base = lb;
									if (sum < 2 * QUAL_BASE)
										r.qual = QUAL_BASE[7:0];
									else if (sum - QUAL_BASE > QUAL_TOP)
										r.qual = QUAL_TOP[7:0];
									else
										r.qual = 8'(sum - QUAL_BASE);
								end
							end
						end
					end
				end
				pending_reports.push_back(r);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	function automatic void report_failure(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got)
			report_failure($sformatf("%s expected %0d, actual %0d", what, want, got));
	endfunction

	always @(posedge clk) begin : check_reports
		merge_report_t want;
		merge_report_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.overlapped = m_axis_tdata[0];
			got.offset     = m_axis_tdata[9:1];
			got.ovl_len    = m_axis_tdata[18:10];
			got.diffs      = m_axis_tdata[22:19];
			got.merged_len = m_axis_tdata[32:23];
			got.base       = m_axis_tdata[40:33];
			got.qual       = m_axis_tdata[48:41];
			if (pending_reports.size() == 0) begin
				report_failure($sformatf("unexpected transaction, expected none, actual %h",
					m_axis_tdata));
			end else begin
				want = pending_reports.pop_front();
				check_field("overlapped", want.overlapped, got.overlapped);
				check_field("offset", want.offset, got.offset);
				check_field("overlap_len", want.ovl_len, got.ovl_len);
				check_field("diff_count", want.diffs, got.diffs);
				check_field("merged_len", want.merged_len, got.merged_len);
				check_field("out_base", want.base, got.base);
				check_field("out_qual", want.qual, got.qual);
			end
		end
	end

	// receiver backpressure
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	// entered and left at a falling edge; tvalid stays high between items unless a random gap is inserted
	task automatic send_item(input kind_t k, input bit first, input logic [7:0] b,
			input logic [7:0] q, input logic [8:0] pos);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, pos, q, b};
		s_axis_tuser  <= {first, k};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_item(k, first, b, q, pos);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_cmd(input kind_t k, input logic [8:0] pos);
		send_item(k, 1'($urandom), 8'($urandom), 8'($urandom), pos);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [8:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MIN_OVERLAP: min_ovl = value;
			CFG_HIGH_QUAL:   hi_q = value[6:0];
			CFG_LOW_QUAL:    lo_q = value[6:0];
			CFG_MAX_LOW:     low_cap = value[3:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [8:0] mo, input logic [6:0] hq,
			input logic [6:0] lq, input logic [3:0] ml);
		drain();
		write_reg(CFG_MIN_OVERLAP, mo);
		write_reg(CFG_HIGH_QUAL, {2'b0, hq});
		write_reg(CFG_LOW_QUAL, {2'b0, lq});
		write_reg(CFG_MAX_LOW, {5'b0, ml});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_base();
		case ($urandom_range(0, 15))
			0: return 8'($urandom);
			1: return "N";
			2, 3, 4: return "A";
			5, 6, 7: return "C";
			8, 9, 10: return "G";
			default: return "T";
		endcase
	endfunction

	function automatic logic [7:0] pick_qual();
		case ($urandom_range(0, 9))
			0, 1: return 8'($urandom);
			2: return 8'($urandom_range(30, 70));
			default: return 8'($urandom_range(33, 75));
		endcase
	endfunction

	// one left/right pair built with a planted overlap, then merge and fetches
	task automatic read_pair(input int max_len);
		logic [7:0] lb [$];
		logic [7:0] lq [$];
		logic [7:0] rb [$];
		logic [7:0] rq [$];
		int nl, nr, olen, off, li, ri, mut_pct;
		nl = $urandom_range(1, max_len);
		nr = $urandom_range(1, max_len);
		olen = $urandom_range(1, (nl < nr) ? nl : nr);
		off = nl - olen;
		mut_pct = $urandom_range(0, 12);
		for (int i = 0; i < nl; i++) begin
			lb.push_back(pick_base());
			lq.push_back(pick_qual());
		end
		// rb/rq hold the right read in reverse-complement order
		for (int i = 0; i < nr; i++) begin
			rb.push_back((i < olen) ? lb[off + i] : pick_base());
			rq.push_back(pick_qual());
			if (i < olen && $urandom_range(0, 99) < mut_pct) begin
				rb[i] = ($urandom_range(0, 3) == 0) ? pick_base() : strand_swap(rb[i]);
				case ($urandom_range(0, 3))
					0: begin
						lq[off + i] = 8'($urandom_range(hi_q, 255));
						rq[i] = 8'($urandom_range(0, lo_q));
					end
					1: begin
						lq[off + i] = 8'($urandom_range(0, lo_q));
						rq[i] = 8'($urandom_range(hi_q, 255));
					end
					default: ;
				endcase
			end
		end
		li = 0;
		ri = 0;
		while (li < nl || ri < nr) begin
			if ($urandom_range(0, 49) == 0)
				send_cmd(($urandom_range(0, 1) != 0) ? KIND_FETCH : KIND_MERGE, 9'($urandom));
			if (ri >= nr || (li < nl && $urandom_range(0, 1) != 0)) begin
				send_item(KIND_LOAD_LEFT,
					(li == 0) ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 99) == 0),
					lb[li], lq[li], 9'($urandom));
				li++;
			end else begin
				send_item(KIND_LOAD_RIGHT,
					(ri == 0) ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 99) == 0),
					strand_swap(rb[nr - 1 - ri]), rq[nr - 1 - ri], 9'($urandom));
				ri++;
			end
		end
		send_cmd(KIND_MERGE, 9'($urandom));
		repeat ($urandom_range(2, 10)) begin
			if ($urandom_range(0, 9) == 0)
				send_cmd(KIND_FETCH, 9'($urandom));
			else
				send_cmd(KIND_FETCH, 9'($urandom_range(0, nl + nr)));
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_reset_state();
		send_cmd(KIND_FETCH, 9'd0);
		send_cmd(KIND_MERGE, 9'd511);
	endtask

	// zero min overlap and zero mismatch budget, quality clamps both ways,
	// load after merge, no-overlap result
	task automatic test_special_cases();
		apply_config(9'd0, 7'd63, 7'd48, 4'd0);
		send_item(KIND_LOAD_LEFT, 1'b1, "G", 8'hff, 9'd0);
		send_item(KIND_LOAD_LEFT, 1'b0, "A", 8'h00, 9'h1ff);
		send_item(KIND_LOAD_LEFT, 1'b0, "T", 8'd40, 9'd0);
		send_item(KIND_LOAD_RIGHT, 1'b1, "A", 8'd50, 9'd0);
		send_item(KIND_LOAD_RIGHT, 1'b0, "T", 8'd20, 9'h1ff);
		send_item(KIND_LOAD_RIGHT, 1'b0, "C", 8'd70, 9'd0);
		send_cmd(KIND_MERGE, 9'd0);
		for (int p = 0; p < 4; p++)
			send_cmd(KIND_FETCH, 9'(p));
		send_cmd(KIND_FETCH, 9'd511);
		send_item(KIND_LOAD_LEFT, 1'b0, "C", 8'd70, 9'd0);
		send_cmd(KIND_FETCH, 9'd0);
		send_cmd(KIND_MERGE, 9'd0);
		send_cmd(KIND_FETCH, 9'd1);
	endtask

	// both reads past capacity, single overlap length at the maximum
	task automatic test_full_reads();
		logic [7:0] lb [$];
		logic [7:0] lq [$];
		logic [7:0] rb [$];
		logic [7:0] rq [$];
		apply_config(9'd256, 7'd126, 7'd33, 4'd15);
		for (int i = 0; i < READ_CAP; i++) begin
			lb.push_back(pick_base());
			lq.push_back(pick_qual());
			rb.push_back(lb[i]);
			rq.push_back(pick_qual());
		end
		rb[10] = lb[10] ^ 8'h01;
		lq[10] = 8'($urandom_range(126, 255));
		rq[10] = 8'($urandom_range(0, 33));
		rb[200] = lb[200] ^ 8'h01;
		lq[200] = 8'($urandom_range(0, 33));
		rq[200] = 8'($urandom_range(126, 255));
		for (int i = 0; i < READ_CAP + 2; i++)
			send_item(KIND_LOAD_LEFT, i == 0, (i < READ_CAP) ? lb[i] : pick_base(),
				(i < READ_CAP) ? lq[i] : pick_qual(), 9'($urandom));
		for (int i = 0; i < READ_CAP + 1; i++)
			send_item(KIND_LOAD_RIGHT, i == 0,
				(i < READ_CAP) ? strand_swap(rb[READ_CAP - 1 - i]) : pick_base(),
				(i < READ_CAP) ? rq[READ_CAP - 1 - i] : pick_qual(), 9'($urandom));
		send_cmd(KIND_MERGE, 9'd0);
		send_cmd(KIND_FETCH, 9'd0);
		send_cmd(KIND_FETCH, 9'd10);
		send_cmd(KIND_FETCH, 9'd200);
		send_cmd(KIND_FETCH, 9'd255);
		send_cmd(KIND_FETCH, 9'd256);
		send_cmd(KIND_FETCH, 9'd511);
		repeat (4) send_cmd(KIND_FETCH, 9'($urandom_range(0, 255)));
	endtask

	task automatic test_random_pairs(input int n, input int max_len);
		int goal;
		goal = items_sent + n;
		gap_pct = $urandom_range(0, 30);
		while (items_sent < goal)
			read_pair(max_len);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_special_cases();
		test_full_reads();

		apply_config(9'd1, 7'd126, 7'd33, 4'd1);
		test_random_pairs(150, 24);
		apply_config(9'd3, 7'd33, 7'd126, 4'd15);
		test_random_pairs(150, 24);
		repeat (4) begin
			apply_config(9'($urandom_range(0, 12)), 7'($urandom_range(50, 75)),
				7'($urandom_range(30, 55)), 4'($urandom_range(0, 15)));
			test_random_pairs(150, 40);
		end

		calm = 1'b1;
		apply_config(9'($urandom_range(1, 8)), 7'd60, 7'd45, 4'($urandom_range(1, 15)));
		test_random_pairs(150, 32);

		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/prom_pkg.sv
hw/rtl/prom_ram.sv
hw/rtl/paired_read_overlap_merge.sv
bench/paired_read_overlap_merge_tb.sv
